>>> rtl/svml_pkg.sv
`default_nettype none

package svml_pkg;

    // payload widths
    localparam int MODE_W     = 3;
    localparam int COORD_W    = 16;
    localparam int ROOT_W     = 2;
    localparam int ENTRY_W    = 12;
    localparam int MASK_W     = 64;
    localparam int LINK_IDX_W = 12;
    localparam int LINK_W     = LINK_IDX_W + 1;
    localparam int MAT_W      = 8;

    // leaf word: first material, homogeneous flag, material
    localparam int LEAF_W     = LINK_IDX_W + 1 + MAT_W;
    localparam int LEAF_HOMO  = MAT_W;

    // configuration registers
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int UCNT_W     = 3;
    localparam int LCNT_W     = 9;
    localparam int LFCNT_W    = 13;
    localparam int MCNT_W     = 13;
    localparam int DEPTH_W    = 4;

    // walk arithmetic
    localparam int IDX_W      = LINK_IDX_W + 1;
    localparam int OFF_W      = $clog2(MASK_W + 1);
    localparam int SHIFT_W    = 6;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP      = 3'd0,
        MODE_WR_UPPER    = 3'd1,
        MODE_WR_LOWER    = 3'd2,
        MODE_WR_LEAF     = 3'd3,
        MODE_WR_MATERIAL = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER_COUNT    = 3'd0,
        CFG_LOWER_COUNT    = 3'd1,
        CFG_LEAF_COUNT     = 3'd2,
        CFG_MATERIAL_COUNT = 3'd3,
        CFG_ROOT_DEPTH     = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_UPPER = 3'd1,
        ST_LOWER = 3'd2,
        ST_LEAF  = 3'd3,
        ST_MAT   = 3'd4
    } state_t;

    typedef struct packed {
        logic accept;
        logic do_upper;
        logic do_lower;
        logic do_leaf;
        logic load_out;
    } svml_cmd_t;

    typedef struct packed {
        logic lookup_req;
        logic out_free;
    } svml_status_t;

endpackage

`default_nettype wire

>>> rtl/svml_if.sv
`default_nettype none

interface svml_item_if;
    logic                              valid;
    logic                              ready;
    logic [svml_pkg::MODE_W-1:0]       mode;
    logic [svml_pkg::COORD_W-1:0]      coord_x;
    logic [svml_pkg::COORD_W-1:0]      coord_y;
    logic [svml_pkg::COORD_W-1:0]      coord_z;
    logic [svml_pkg::ROOT_W-1:0]       root_index;
    logic [svml_pkg::ENTRY_W-1:0]      entry_index;
    logic [svml_pkg::MASK_W-1:0]       child_mask;
    logic [svml_pkg::LINK_IDX_W-1:0]   first_index;
    logic                              link_valid;
    logic                              homogeneous;
    logic [svml_pkg::MAT_W-1:0]        material_value;

    modport source (
        output valid, mode, coord_x, coord_y, coord_z, root_index, entry_index,
               child_mask, first_index, link_valid, homogeneous, material_value,
        input  ready
    );
    modport sink (
        input  valid, mode, coord_x, coord_y, coord_z, root_index, entry_index,
               child_mask, first_index, link_valid, homogeneous, material_value,
        output ready
    );
endinterface

interface svml_result_if;
    logic                        valid;
    logic                        ready;
    logic [svml_pkg::MAT_W-1:0]  material;

    modport source (output valid, material, input ready);
    modport sink (input valid, material, output ready);
endinterface

interface svml_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [svml_pkg::CFG_IDX_W-1:0]   index;
    logic [svml_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/sparse_voxel_material_lookup.sv
// Channel   Dir  Words carried
// -------   ---  ---------------------------------------------------------
// item      in   lookups (coords, root) and table writes (upper/lower/leaf/material)
// result    out  one material byte per lookup word; writes give none
// cfg       in   register index and data: counts and root depth
//
// A table write is taken on its acceptance edge; the item side stays ready after it.
// A lookup holds the item side through its walk: the acceptance edge reads the upper
// node, the UPPER, LOWER and LEAF states then read lower node, leaf and material list,
// and the MAT state loads the result register; only then is a new word taken.
// A held result stalls only that load step. Reset clears the counts, the root depth and
// the control state; tables are not cleared. Config writes are taken in any cycle.
`default_nettype none

module sparse_voxel_material_lookup #(
    parameter int BITS_PER_AXIS     = 2,
    parameter int CHILDREN_PER_NODE = 64,
    parameter int UPPER_DEPTH       = 4,
    parameter int LOWER_DEPTH       = 256,
    parameter int LEAF_DEPTH        = 4096,
    parameter int MATERIAL_DEPTH    = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    svml_item_if.sink     item,
    svml_result_if.source result,
    svml_cfg_if.sink      cfg
);
    import svml_pkg::*;

    svml_cmd_t    cmd;
    svml_status_t status;

    // sequencer: owns the item handshake and steps the walk
    svml_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // tables, walk registers, config registers and result register
    svml_dp #(
        .BITS_PER_AXIS     (BITS_PER_AXIS),
        .CHILDREN_PER_NODE (CHILDREN_PER_NODE),
        .UPPER_DEPTH       (UPPER_DEPTH),
        .LOWER_DEPTH       (LOWER_DEPTH),
        .LEAF_DEPTH        (LEAF_DEPTH),
        .MATERIAL_DEPTH    (MATERIAL_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .mode           (item.mode),
        .coord_x        (item.coord_x),
        .coord_y        (item.coord_y),
        .coord_z        (item.coord_z),
        .root_index     (item.root_index),
        .entry_index    (item.entry_index),
        .child_mask     (item.child_mask),
        .first_index    (item.first_index),
        .link_valid     (item.link_valid),
        .homogeneous    (item.homogeneous),
        .material_value (item.material_value),
        .cfg            (cfg),
        .result         (result)
    );

endmodule

`default_nettype wire

>>> rtl/svml_ctrl.sv
`default_nettype none

module svml_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  svml_pkg::svml_status_t status,
    output svml_pkg::svml_cmd_t    cmd
);
    import svml_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.lookup_req)
                begin
                    state_next = ST_UPPER;
                end
            end
            ST_UPPER: state_next = ST_LOWER;
            ST_LOWER: state_next = ST_LEAF;
            ST_LEAF:  state_next = ST_MAT;
            ST_MAT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_UPPER: cmd.do_upper = 1'b1;
            ST_LOWER: cmd.do_lower = 1'b1;
            ST_LEAF:  cmd.do_leaf  = 1'b1;
            ST_MAT:   cmd.load_out = status.out_free;
            default:  in_ready     = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/svml_dp.sv
`default_nettype none

module svml_dp #(
    parameter int BITS_PER_AXIS     = 2,
    parameter int CHILDREN_PER_NODE = 64,
    parameter int UPPER_DEPTH       = 4,
    parameter int LOWER_DEPTH       = 256,
    parameter int LEAF_DEPTH        = 4096,
    parameter int MATERIAL_DEPTH    = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  svml_pkg::svml_cmd_t                cmd,
    output svml_pkg::svml_status_t             status,
    input  logic [svml_pkg::MODE_W-1:0]        mode,
    input  logic [svml_pkg::COORD_W-1:0]       coord_x,
    input  logic [svml_pkg::COORD_W-1:0]       coord_y,
    input  logic [svml_pkg::COORD_W-1:0]       coord_z,
    input  logic [svml_pkg::ROOT_W-1:0]        root_index,
    input  logic [svml_pkg::ENTRY_W-1:0]       entry_index,
    input  logic [svml_pkg::MASK_W-1:0]        child_mask,
    input  logic [svml_pkg::LINK_IDX_W-1:0]    first_index,
    input  logic                               link_valid,
    input  logic                               homogeneous,
    input  logic [svml_pkg::MAT_W-1:0]         material_value,
    svml_cfg_if.sink                           cfg,
    svml_result_if.source                      result
);
    import svml_pkg::*;

    localparam int UA_W = (UPPER_DEPTH > 1) ? $clog2(UPPER_DEPTH) : 1;
    localparam int LA_W = $clog2(LOWER_DEPTH);
    localparam int LF_W = $clog2(LEAF_DEPTH);
    localparam int MA_W = $clog2(MATERIAL_DEPTH);
    localparam int CI_W = 3 * BITS_PER_AXIS;
    localparam int NODE_W = LINK_W + MASK_W;

    // ---------------- configuration ----------------
    logic [UCNT_W-1:0]  upper_count_reg,    upper_count_next;
    logic [LCNT_W-1:0]  lower_count_reg,    lower_count_next;
    logic [LFCNT_W-1:0] leaf_count_reg,     leaf_count_next;
    logic [MCNT_W-1:0]  material_count_reg, material_count_next;
    logic [DEPTH_W-1:0] root_depth_reg,     root_depth_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        upper_count_next    = upper_count_reg;
        lower_count_next    = lower_count_reg;
        leaf_count_next     = leaf_count_reg;
        material_count_next = material_count_reg;
        root_depth_next     = root_depth_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_UPPER_COUNT:    upper_count_next    = cfg.data[UCNT_W-1:0];
                CFG_LOWER_COUNT:    lower_count_next    = cfg.data[LCNT_W-1:0];
                CFG_LEAF_COUNT:     leaf_count_next     = cfg.data[LFCNT_W-1:0];
                CFG_MATERIAL_COUNT: material_count_next = cfg.data[MCNT_W-1:0];
                CFG_ROOT_DEPTH:     root_depth_next     = cfg.data[DEPTH_W-1:0];
                default:            root_depth_next     = root_depth_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_count_reg    <= '0;
            lower_count_reg    <= '0;
            leaf_count_reg     <= '0;
            material_count_reg <= '0;
            root_depth_reg     <= '0;
        end
        else
        begin
            upper_count_reg    <= upper_count_next;
            lower_count_reg    <= lower_count_next;
            leaf_count_reg     <= leaf_count_next;
            material_count_reg <= material_count_next;
            root_depth_reg     <= root_depth_next;
        end
    end

    // ---------------- item decode ----------------
    logic              is_lookup;
    logic              rd_upper;
    logic              wr_upper;
    logic              wr_lower;
    logic              wr_leaf;
    logic              wr_mat;
    logic [LINK_W-1:0] wr_link;

    assign is_lookup = (mode_t'(mode) == MODE_LOOKUP);
    assign rd_upper  = cmd.accept && is_lookup;
    assign wr_upper  = cmd.accept && (mode_t'(mode) == MODE_WR_UPPER)
                       && (32'(entry_index) < UPPER_DEPTH);
    assign wr_lower  = cmd.accept && (mode_t'(mode) == MODE_WR_LOWER)
                       && (32'(entry_index) < LOWER_DEPTH);
    assign wr_leaf   = cmd.accept && (mode_t'(mode) == MODE_WR_LEAF)
                       && (32'(entry_index) < LEAF_DEPTH);
    assign wr_mat    = cmd.accept && (mode_t'(mode) == MODE_WR_MATERIAL)
                       && (32'(entry_index) < MATERIAL_DEPTH);
    assign wr_link   = {link_valid, first_index};

    // ---------------- tables ----------------
    logic [NODE_W-1:0] upper_mem [UPPER_DEPTH];
    logic [NODE_W-1:0] lower_mem [LOWER_DEPTH];
    logic [LEAF_W-1:0] leaf_mem  [LEAF_DEPTH];
    logic [MAT_W-1:0]  mat_mem   [MATERIAL_DEPTH];

    logic [NODE_W-1:0] upper_rd_reg;
    logic [NODE_W-1:0] lower_rd_reg;
    logic [LEAF_W-1:0] leaf_rd_reg;
    logic [MAT_W-1:0]  mat_rd_reg;

    logic [IDX_W-1:0]  lower_idx;
    logic [IDX_W-1:0]  leaf_idx;
    logic [IDX_W-1:0]  mat_idx;

    always_ff @(posedge clk)
    begin
        if (wr_upper)
        begin
            upper_mem[UA_W'(entry_index)] <= {wr_link, child_mask};
        end
        if (rd_upper)
        begin
            upper_rd_reg <= upper_mem[UA_W'(root_index)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_lower)
        begin
            lower_mem[LA_W'(entry_index)] <= {wr_link, child_mask};
        end
        if (cmd.do_upper)
        begin
            lower_rd_reg <= lower_mem[LA_W'(lower_idx)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_leaf)
        begin
            leaf_mem[LF_W'(entry_index)] <= {first_index, homogeneous, material_value};
        end
        if (cmd.do_lower)
        begin
            leaf_rd_reg <= leaf_mem[LF_W'(leaf_idx)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_mat)
        begin
            mat_mem[MA_W'(entry_index)] <= material_value;
        end
        if (cmd.do_leaf)
        begin
            mat_rd_reg <= mat_mem[MA_W'(mat_idx)];
        end
    end

    // ---------------- walk ----------------
    logic [COORD_W-1:0] cx_reg, cx_next;
    logic [COORD_W-1:0] cy_reg, cy_next;
    logic [COORD_W-1:0] cz_reg, cz_next;
    logic               fail_reg, fail_next;
    logic [OFF_W-1:0]   offset_reg, offset_next;
    logic               homo_reg, homo_next;
    logic [MAT_W-1:0]   homo_mat_reg, homo_mat_next;

    logic               root_ok;

    // upper step
    logic [DEPTH_W-1:0] depth_eff;
    logic [SHIFT_W-1:0] shift;
    logic [COORD_W-1:0] sx, sy, sz;
    logic [CI_W-1:0]    ui;
    logic [LINK_W-1:0]  ulink;
    logic [MASK_W-1:0]  umask;
    logic               upper_fail;

    // lower step
    logic [CI_W-1:0]    li;
    logic [LINK_W-1:0]  llink;
    logic [MASK_W-1:0]  lmask;
    logic [MASK_W-1:0]  below;
    logic [OFF_W-1:0]   offset;
    logic               lower_fail;

    // leaf step
    logic               lf_homo;
    logic               leaf_fail;

    assign root_ok = ({1'b0, root_index} < upper_count_reg)
                     && (32'(root_index) < UPPER_DEPTH);

    assign depth_eff = (root_depth_reg >= DEPTH_W'(2)) ? (root_depth_reg - DEPTH_W'(1))
                                                       : '0;
    assign shift = SHIFT_W'(BITS_PER_AXIS) * SHIFT_W'(depth_eff);
    assign sx    = cx_reg >> shift;
    assign sy    = cy_reg >> shift;
    assign sz    = cz_reg >> shift;
    assign ui    = {sz[BITS_PER_AXIS-1:0], sy[BITS_PER_AXIS-1:0], sx[BITS_PER_AXIS-1:0]};
    assign ulink = upper_rd_reg[NODE_W-1:MASK_W];
    assign umask = upper_rd_reg[MASK_W-1:0];

    assign lower_idx  = IDX_W'(ulink[LINK_IDX_W-1:0]) + IDX_W'(ui);
    assign upper_fail = !ulink[LINK_W-1]
                        || (32'(ui) >= CHILDREN_PER_NODE)
                        || !umask[ui]
                        || (lower_idx >= IDX_W'(lower_count_reg))
                        || (32'(lower_idx) >= LOWER_DEPTH);

    assign li    = {cz_reg[BITS_PER_AXIS-1:0], cy_reg[BITS_PER_AXIS-1:0],
                    cx_reg[BITS_PER_AXIS-1:0]};
    assign llink = lower_rd_reg[NODE_W-1:MASK_W];
    assign lmask = lower_rd_reg[MASK_W-1:0];
    // mask bits below the child give the leaf offset
    assign below  = lmask & ((MASK_W'(1) << li) - MASK_W'(1));
    assign offset = OFF_W'($countones(below));

    assign leaf_idx   = IDX_W'(llink[LINK_IDX_W-1:0]) + IDX_W'(offset);
    assign lower_fail = !llink[LINK_W-1]
                        || (32'(li) >= CHILDREN_PER_NODE)
                        || !lmask[li]
                        || (leaf_idx >= IDX_W'(leaf_count_reg))
                        || (32'(leaf_idx) >= LEAF_DEPTH);

    assign lf_homo   = leaf_rd_reg[LEAF_HOMO];
    assign mat_idx   = IDX_W'(leaf_rd_reg[LEAF_W-1:LEAF_HOMO+1]) + IDX_W'(offset_reg);
    assign leaf_fail = !lf_homo
                       && ((mat_idx >= IDX_W'(material_count_reg))
                           || (32'(mat_idx) >= MATERIAL_DEPTH));

    always_comb
    begin
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        fail_next     = fail_reg;
        offset_next   = offset_reg;
        homo_next     = homo_reg;
        homo_mat_next = homo_mat_reg;
        if (rd_upper)
        begin
            cx_next   = coord_x;
            cy_next   = coord_y;
            cz_next   = coord_z;
            fail_next = !root_ok;
        end
        if (cmd.do_upper)
        begin
            fail_next = fail_reg || upper_fail;
        end
        if (cmd.do_lower)
        begin
            fail_next   = fail_reg || lower_fail;
            offset_next = offset;
        end
        if (cmd.do_leaf)
        begin
            fail_next     = fail_reg || leaf_fail;
            homo_next     = lf_homo;
            homo_mat_next = leaf_rd_reg[MAT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        fail_reg     <= fail_next;
        offset_reg   <= offset_next;
        homo_reg     <= homo_next;
        homo_mat_reg <= homo_mat_next;
    end

    // ---------------- result register ----------------
    logic             result_valid_reg, result_valid_next;
    logic [MAT_W-1:0] material_reg, material_next;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        material_next     = material_reg;
        if (result.ready)
        begin
            result_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            result_valid_next = 1'b1;
            if (fail_reg)
            begin
                material_next = '0;
            end
            else if (homo_reg)
            begin
                material_next = homo_mat_reg;
            end
            else
            begin
                material_next = mat_rd_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        material_reg <= material_next;
    end

    assign result.valid    = result_valid_reg;
    assign result.material = material_reg;

    assign status.lookup_req = is_lookup;
    assign status.out_free   = !result_valid_reg || result.ready;

endmodule

`default_nettype wire
